### sv/tbme_pkg.sv
// ----------------------------------------------------------------------------
// tbme_pkg: shared types and constants for two-button Morse entry
// Event codes, config register indexes, reset values, Morse lookup and
// the receiver-id step.
// ----------------------------------------------------------------------------
package tbme_pkg;

  // Event codes carried on the result word
  typedef enum logic [2:0] {
    EV_NONE = 3'd0,
    EV_DOT  = 3'd1,
    EV_DASH = 3'd2,
    EV_SAVE = 3'd3,
    EV_SEND = 3'd4,
    EV_BOTH = 3'd5
  } ev_t;

  // Config register indexes
  localparam logic CFG_IDX_THRESHOLD = 1'b0;
  localparam logic CFG_IDX_ID_COUNT  = 1'b1;

  localparam logic [15:0] THRESHOLD_RST   = 16'd200;
  localparam logic [4:0]  ID_COUNT_RST    = 5'd6;
  localparam logic [3:0]  RECEIVER_RST    = 4'd1;
  localparam logic [15:0] HOLD_MAX        = 16'hFFFF;
  localparam logic [6:0]  CHAR_UNKNOWN    = 7'h3F;  // '?'

  localparam int MESSAGE_CAPACITY_DEF   = 32;
  localparam int SYMBOLS_PER_LETTER_DEF = 5;

  // Morse lookup: key is {count, bits}, bit i is symbol i, 1 = dash
  function automatic logic [6:0] morse_decode(input logic [2:0] cnt,
                                              input logic [4:0] bits);
    logic [6:0] ch;
    unique case ({cnt, bits})
      {3'd2, 5'b00010}: ch = 7'h41;  // A
      {3'd4, 5'b00001}: ch = 7'h42;  // B
      {3'd4, 5'b00101}: ch = 7'h43;  // C
      {3'd3, 5'b00001}: ch = 7'h44;  // D
      {3'd1, 5'b00000}: ch = 7'h45;  // E
      {3'd4, 5'b00100}: ch = 7'h46;  // F
      {3'd3, 5'b00011}: ch = 7'h47;  // G
      {3'd4, 5'b00000}: ch = 7'h48;  // H
      {3'd2, 5'b00000}: ch = 7'h49;  // I
      {3'd4, 5'b01110}: ch = 7'h4A;  // J
      {3'd3, 5'b00101}: ch = 7'h4B;  // K
      {3'd4, 5'b00010}: ch = 7'h4C;  // L
      {3'd2, 5'b00011}: ch = 7'h4D;  // M
      {3'd2, 5'b00001}: ch = 7'h4E;  // N
      {3'd3, 5'b00111}: ch = 7'h4F;  // O
      {3'd4, 5'b00110}: ch = 7'h50;  // P
      {3'd4, 5'b01011}: ch = 7'h51;  // Q
      {3'd3, 5'b00010}: ch = 7'h52;  // R
      {3'd3, 5'b00000}: ch = 7'h53;  // S
      {3'd1, 5'b00001}: ch = 7'h54;  // T
      {3'd3, 5'b00100}: ch = 7'h55;  // U
      {3'd4, 5'b01000}: ch = 7'h56;  // V
      {3'd3, 5'b00110}: ch = 7'h57;  // W
      {3'd4, 5'b01001}: ch = 7'h58;  // X
      {3'd4, 5'b01101}: ch = 7'h59;  // Y
      {3'd4, 5'b00011}: ch = 7'h5A;  // Z
      {3'd5, 5'b11111}: ch = 7'h30;  // 0
      {3'd5, 5'b11110}: ch = 7'h31;  // 1
      {3'd5, 5'b11100}: ch = 7'h32;  // 2
      {3'd5, 5'b11000}: ch = 7'h33;  // 3
      {3'd5, 5'b10000}: ch = 7'h34;  // 4
      {3'd5, 5'b00000}: ch = 7'h35;  // 5
      {3'd5, 5'b00001}: ch = 7'h36;  // 6
      {3'd5, 5'b00011}: ch = 7'h37;  // 7
      {3'd5, 5'b00111}: ch = 7'h38;  // 8
      {3'd5, 5'b01111}: ch = 7'h39;  // 9
      default:          ch = CHAR_UNKNOWN;
    endcase
    return ch;
  endfunction

  // (cur + 1) mod n, kept to 4 bits; n of 0 gives 0.
  // cur + 1 is at most 16, so for n >= 2 eight subtract steps are enough.
  function automatic logic [3:0] receiver_step(input logic [3:0] cur,
                                               input logic [4:0] n);
    logic [4:0] r;
    r = {1'b0, cur} + 5'd1;
    if (n <= 5'd1) begin
      r = 5'd0;
    end else begin
      for (int i = 0; i < 8; i++) begin
        if (r >= n) begin
          r = r - n;
        end
      end
    end
    return r[3:0];
  endfunction

endpackage

### sv/two_button_morse_entry_top.sv
// ----------------------------------------------------------------------------
// two_button_morse_entry_top: two-button Morse keyer front end
// Samples buttons A and B, classifies releases, decodes letters and digits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one word per millisecond sample,
//   carrying the levels of button A (dot/dash) and button B (save/send).
//   Output channel (out_valid/out_ready): exactly one result word per
//   input word: event code, decoded character (on save), message length
//   and the current receiver id.
//   Config port: cfg_we writes cfg_wdata into register cfg_index
//   (0 = dash threshold in ms, 1 = receiver id count). Write only while
//   no word is in flight.
//   The result is registered, so it shows in the cycle after the input
//   word is accepted. Throughput: one word per cycle unless the output
//   stalls; all button, symbol and message state updates in the accepting
//   cycle, and the Morse lookup is a small constant decode in the same cycle.
//   Stall: a pending result sits in the output register; a new word is
//   still taken in the cycle the receiver pops the old one (in_ready
//   follows out_ready when the output register is full).
//   Reset (rst_n low, synchronous): buttons released, counters and message
//   cleared, receiver id 1, threshold 200 ms, id count 6, no result pending.
// ----------------------------------------------------------------------------
module two_button_morse_entry_top #(
  parameter int MESSAGE_CAPACITY   = tbme_pkg::MESSAGE_CAPACITY_DEF,
  parameter int SYMBOLS_PER_LETTER = tbme_pkg::SYMBOLS_PER_LETTER_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // config write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  // sample words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_button_a_down,
  input  logic        in_button_b_down,
  // result words
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_code,
  output logic        out_char_valid,
  output logic [6:0]  out_char_code,
  output logic [4:0]  out_char_index,
  output logic [5:0]  out_message_length,
  output logic [3:0]  out_dest_id
);

  localparam logic [5:0] MSG_CAP = 6'(MESSAGE_CAPACITY);
  localparam logic [2:0] SYM_CAP = 3'(SYMBOLS_PER_LETTER);

  // config registers
  logic [15:0] thresh_r;
  logic [4:0]  id_count_r;

  // sampler state
  logic        a_pressed_r, a_pressed_nxt;
  logic        b_pressed_r, b_pressed_nxt;
  logic [15:0] a_held_r, a_held_nxt;
  logic [15:0] b_held_r, b_held_nxt;
  logic        latch_r, latch_nxt;
  // symbol / message state
  logic [2:0]  sym_cnt_r, sym_cnt_nxt;
  logic [4:0]  sym_bits_r, sym_bits_nxt;
  logic [5:0]  msg_cnt_r, msg_cnt_nxt;
  logic [3:0]  rcv_r, rcv_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  ev_r;
  logic        cv_r;
  logic [6:0]  cc_r;
  logic [4:0]  ci_r;
  logic [5:0]  len_r;

  tbme_pkg::ev_t ev;
  logic          cv;
  logic [6:0]    cc;
  logic [4:0]    ci;
  logic [5:0]    len;
  logic          accept;
  logic          a_rel, b_rel, latch_s;
  logic [5:0]    msg_after_save;

  assign in_ready = ~out_valid_r | out_ready;
  assign accept   = in_valid & in_ready;

  // Next state and result for one sample
  always_comb begin
    // hold counters count while pressed, restart on a fresh press
    a_held_nxt    = a_held_r;
    b_held_nxt    = b_held_r;
    if (a_pressed_r && a_held_r != tbme_pkg::HOLD_MAX) a_held_nxt = a_held_r + 16'd1;
    if (b_pressed_r && b_held_r != tbme_pkg::HOLD_MAX) b_held_nxt = b_held_r + 16'd1;
    if (in_button_a_down && !a_pressed_r) a_held_nxt = '0;
    if (in_button_b_down && !b_pressed_r) b_held_nxt = '0;
    a_pressed_nxt = a_pressed_r | in_button_a_down;
    b_pressed_nxt = b_pressed_r | in_button_b_down;
    latch_s       = latch_r | (in_button_a_down & in_button_b_down);
    latch_nxt     = latch_s;

    // only one release per sample, A first
    a_rel = ~in_button_a_down & a_pressed_r;
    b_rel = ~in_button_b_down & b_pressed_r & ~a_rel;
    ev    = tbme_pkg::EV_NONE;
    if (a_rel) begin
      a_pressed_nxt = 1'b0;
      if (latch_s) begin
        if (!in_button_b_down) latch_nxt = 1'b0;
        ev = in_button_b_down ? tbme_pkg::EV_BOTH : tbme_pkg::EV_NONE;
      end else begin
        ev = (a_held_nxt < thresh_r) ? tbme_pkg::EV_DOT : tbme_pkg::EV_DASH;
      end
    end else if (b_rel) begin
      b_pressed_nxt = 1'b0;
      if (latch_s) begin
        if (!in_button_a_down) latch_nxt = 1'b0;
        ev = in_button_a_down ? tbme_pkg::EV_BOTH : tbme_pkg::EV_NONE;
      end else begin
        ev = (b_held_nxt < thresh_r) ? tbme_pkg::EV_SAVE : tbme_pkg::EV_SEND;
      end
    end

    // symbol buffer, message, receiver id
    sym_cnt_nxt    = sym_cnt_r;
    sym_bits_nxt   = sym_bits_r;
    msg_after_save = msg_cnt_r;
    rcv_nxt        = rcv_r;
    cv             = 1'b0;
    cc             = '0;
    ci             = '0;
    case (ev) inside
      tbme_pkg::EV_DOT, tbme_pkg::EV_DASH: begin
        if (sym_cnt_r < SYM_CAP && sym_cnt_r < 3'd5) begin
          if (ev == tbme_pkg::EV_DASH) sym_bits_nxt[sym_cnt_r] = 1'b1;
          sym_cnt_nxt = sym_cnt_r + 3'd1;
        end
      end
      tbme_pkg::EV_SAVE: begin
        if (sym_cnt_r != 3'd0 && msg_cnt_r < MSG_CAP) begin
          cv             = 1'b1;
          cc             = tbme_pkg::morse_decode(sym_cnt_r, sym_bits_r);
          ci             = msg_cnt_r[4:0];
          msg_after_save = msg_cnt_r + 6'd1;
          sym_cnt_nxt    = '0;
          sym_bits_nxt   = '0;
        end
      end
      tbme_pkg::EV_BOTH: begin
        rcv_nxt = tbme_pkg::receiver_step(rcv_r, id_count_r);
      end
      default: ;
    endcase

    // send reports the length, then clears
    len         = msg_after_save;
    msg_cnt_nxt = msg_after_save;
    if (ev == tbme_pkg::EV_SEND) begin
      msg_cnt_nxt  = '0;
      sym_cnt_nxt  = '0;
      sym_bits_nxt = '0;
    end
  end

  // output register holds until popped
  assign out_valid_nxt = accept | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r    <= tbme_pkg::THRESHOLD_RST;
      id_count_r  <= tbme_pkg::ID_COUNT_RST;
      a_pressed_r <= 1'b0;
      b_pressed_r <= 1'b0;
      a_held_r    <= '0;
      b_held_r    <= '0;
      latch_r     <= 1'b0;
      sym_cnt_r   <= '0;
      sym_bits_r  <= '0;
      msg_cnt_r   <= '0;
      rcv_r       <= tbme_pkg::RECEIVER_RST;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_index == tbme_pkg::CFG_IDX_THRESHOLD) thresh_r <= cfg_wdata;
        if (cfg_index == tbme_pkg::CFG_IDX_ID_COUNT)  id_count_r <= cfg_wdata[4:0];
      end
      if (accept) begin
        a_pressed_r <= a_pressed_nxt;
        b_pressed_r <= b_pressed_nxt;
        a_held_r    <= a_held_nxt;
        b_held_r    <= b_held_nxt;
        latch_r     <= latch_nxt;
        sym_cnt_r   <= sym_cnt_nxt;
        sym_bits_r  <= sym_bits_nxt;
        msg_cnt_r   <= msg_cnt_nxt;
        rcv_r       <= rcv_nxt;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      ev_r  <= ev;
      cv_r  <= cv;
      cc_r  <= cc;
      ci_r  <= ci;
      len_r <= len;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_code     = ev_r;
  assign out_char_valid     = cv_r;
  assign out_char_code      = cc_r;
  assign out_char_index     = ci_r;
  assign out_message_length = len_r;
  assign out_dest_id        = rcv_r;

endmodule
